FILE: src/stis_pkg.sv
// Shared types and constants for the sorted table interval search block.
package stis_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned PosW       = 31;
  localparam int unsigned HitW       = 12;

  typedef enum logic [1:0] {
    ModeClear  = 2'd0,
    ModeAppend = 2'd1,
    ModeQuery  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusOrder = 2'd2
  } status_e;

  // operand pair routed into the shared comparator
  typedef enum logic [1:0] {
    CmpAppend = 2'd0,
    CmpSearch = 2'd1,
    CmpCheck  = 2'd2
  } cmp_sel_e;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

endpackage

FILE: src/sorted_table_interval_search_core.sv
// Top level: sorted position table with lower-bound interval search.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+----------------------------
//  command | mode_i position_i query_start_i query_end_i  | start_i high, busy_o low
//  result  | found_o hit_index_o status_o                 | done_o high for one cycle
//
// Clear, append and an unused mode finish at the accepting edge; the result
// beat follows in the next cycle and busy_o never rises, so such commands may
// come back to back. A query on a non-empty table holds busy_o high through its
// probe states and then a check state; the single read port of the table RAM
// allows one probe per cycle. Reset is asynchronous, active low, and empties the
// table (count to zero); the RAM itself is not cleared. The receiver cannot
// stall result beats.
module sorted_table_interval_search_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            mode_i,
  input  logic [30:0]           position_i,
  input  logic [30:0]           query_start_i,
  input  logic [30:0]           query_end_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic [11:0]           hit_index_o,
  output logic [1:0]            status_o
);
  import stis_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StStep,
    StCheck
  } state_e;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  logic    done_q, done_d;
  logic    found_q, found_d;
  idx_t    hit_q, hit_d;
  status_e status_q, status_d;

  // search payload, no reset needed
  cnt_t    lo_q, lo_d;
  cnt_t    hi_q, hi_d;
  idx_t    mid_q, mid_d;
  pos_t    qs_q, qs_d;
  pos_t    qe_q, qe_d;
  pos_t    last_q, last_d;

  logic     accept;
  mode_e    mode;
  cmp_sel_e cmp_sel;
  logic     lt;
  logic     ram_we;
  idx_t     raddr;
  pos_t     rdata;
  cnt_t     step_lo;
  cnt_t     step_hi;
  cnt_t     step_mid;
  cnt_t     first_mid;

  assign accept = start_i && (state_q == StIdle);
  assign mode   = mode_e'(mode_i);

  always_comb begin
    case (state_q)
      StStep:  cmp_sel = CmpSearch;
      StCheck: cmp_sel = CmpCheck;
      default: cmp_sel = CmpAppend;
    endcase
  end

  stis_cmp u_cmp (
    .sel_i      (cmp_sel),
    .last_pos_i (last_q),
    .new_pos_i  (position_i),
    .rdata_i    (rdata),
    .key_lo_i   (qs_q),
    .key_hi_i   (qe_q),
    .lt_o       (lt)
  );

  stis_ram #(
    .DataW (PosW),
    .Depth (TableDepth),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (position_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // narrow the window by one probe; mid of the new window feeds the next read
  assign step_lo   = lt ? (cnt_t'(mid_q) + cnt_t'(1)) : lo_q;
  assign step_hi   = lt ? hi_q : cnt_t'(mid_q);
  assign step_mid  = step_lo + ((step_hi - step_lo) >> 1);
  assign first_mid = count_q >> 1;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    done_d   = 1'b0;
    found_d  = 1'b0;
    hit_d    = '0;
    status_d = StatusOk;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    qs_d     = qs_q;
    qe_d     = qe_q;
    last_d   = last_q;
    ram_we   = 1'b0;
    raddr    = mid_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (mode)
            ModeClear: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            ModeAppend: begin
              done_d = 1'b1;
              if (count_q == cnt_t'(TableDepth)) begin
                status_d = StatusFull;
              end else if ((count_q != '0) && !lt) begin
                status_d = StatusOrder;
              end else begin
                ram_we  = 1'b1;
                last_d  = position_i;
                count_d = count_q + cnt_t'(1);
              end
            end
            ModeQuery: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                // first probe goes out right away
                lo_d    = '0;
                hi_d    = count_q;
                mid_d   = first_mid[IdxW-1:0];
                raddr   = first_mid[IdxW-1:0];
                qs_d    = query_start_i;
                qe_d    = query_end_i;
                state_d = StStep;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      StStep: begin
        lo_d = step_lo;
        hi_d = step_hi;
        if (step_lo < step_hi) begin
          mid_d = step_mid[IdxW-1:0];
          raddr = step_mid[IdxW-1:0];
        end else begin
          // window closed: fetch the lower bound for the end check
          raddr   = step_lo[IdxW-1:0];
          state_d = StCheck;
        end
      end
      StCheck: begin
        done_d  = 1'b1;
        state_d = StIdle;
        if ((lo_q < count_q) && lt) begin
          found_d = 1'b1;
          hit_d   = lo_q[IdxW-1:0];
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      hit_q    <= '0;
      status_q <= StatusOk;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      found_q  <= found_d;
      hit_q    <= hit_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    qs_q   <= qs_d;
    qe_q   <= qe_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign done_o      = done_q;
  assign found_o     = found_q;
  assign hit_index_o = HitW'(hit_q);
  assign status_o    = status_q;

endmodule

FILE: src/stis_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module stis_ram #(
  parameter int unsigned DataW = 31,
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/stis_cmp.sv
// Shared magnitude comparator with operand select.
module stis_cmp (
  input  stis_pkg::cmp_sel_e sel_i,
  input  stis_pkg::pos_t     last_pos_i,
  input  stis_pkg::pos_t     new_pos_i,
  input  stis_pkg::pos_t     rdata_i,
  input  stis_pkg::pos_t     key_lo_i,
  input  stis_pkg::pos_t     key_hi_i,
  output logic               lt_o
);
  import stis_pkg::*;

  pos_t op_a;
  pos_t op_b;

  always_comb begin
    case (sel_i)
      CmpAppend: begin
        op_a = last_pos_i;
        op_b = new_pos_i;
      end
      CmpSearch: begin
        op_a = rdata_i;
        op_b = key_lo_i;
      end
      CmpCheck: begin
        op_a = rdata_i;
        op_b = key_hi_i;
      end
      default: begin
        op_a = rdata_i;
        op_b = key_lo_i;
      end
    endcase
  end

  assign lt_o = (op_a < op_b);

endmodule

FILE: src/stis_checker.sv
// Port-level checker for the sorted table interval search block, with its bind.
module stis_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  mode_i,
  input logic        done_o,
  input logic        found_o,
  input logic [11:0] hit_index_o,
  input logic [1:0]  status_o
);
  import stis_pkg::*;

  // a hit never comes with a dropped-append status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == StatusOk))
    else $error("hit reported with nonzero status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (hit_index_o == '0))
    else $error("miss reported with nonzero index");

  // only a query keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && (mode_i == ModeQuery)))
    else $error("busy raised by a non-query command");

  // non-query commands answer in the next cycle and leave the block free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i != ModeQuery)) |=> (done_o && !busy_o))
    else $error("non-query command did not complete in one cycle");

  // a query ends with a result beat as busy drops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (done_o && (status_o == StatusOk)))
    else $error("query finished without a clean result beat");

endmodule

bind sorted_table_interval_search_core stis_checker u_stis_checker (.*);
